>>> rtl/core/ps16_pkg.sv
// Shared types and constants for the PCM sample to signed 16-bit converter.
`timescale 1ns / 1ps
package ps16_pkg;
	localparam logic [1:0] FMT_INT16 = 2'd0;
	localparam logic [1:0] FMT_INT24 = 2'd1;
	localparam logic [1:0] FMT_INT32 = 2'd2;
	localparam logic [1:0] FMT_FLOAT = 2'd3;

	localparam logic [1:0] KIND_INT  = 2'd0;
	localparam logic [1:0] KIND_ZERO = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_MUL  = 2'd3;

	localparam logic [14:0] FULL_SCALE = 15'd32767;
	// Below this biased exponent the scaled value rounds to zero.
	localparam logic [7:0] EXP_MIN_NZ = 8'd111;
	localparam logic [7:0] EXP_ONE    = 8'd127;

	typedef struct packed {
		logic [1:0]  kind;
		logic        sign;
		logic [15:0] int_val;
		logic [38:0] prod;
		logic [7:0]  bexp;
		logic        last;
	} prod_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        sign;
		logic [15:0] int_val;
		logic [24:0] r;
		logic [4:0]  t;
		logic        last;
	} rnd_t;
endpackage

>>> rtl/core/ps16_decode.sv
// Format decode, integer narrowing and mantissa scaling multiply.
`timescale 1ns / 1ps
module ps16_decode (
	input  logic [31:0]      word,
	input  logic [1:0]       fmt,
	input  logic             last,
	output ps16_pkg::prod_t  res
);
	import ps16_pkg::*;
	logic [7:0]  bexp;
	logic [22:0] frac;

	always_comb begin
		bexp = word[30:23];
		frac = word[22:0];
		res.sign = word[31];
		res.bexp = bexp;
		res.last = last;
		res.prod = {1'b1, frac} * FULL_SCALE;
		res.int_val = word[15:0];
		res.kind = KIND_INT;
		unique case (fmt)
			FMT_INT24: res.int_val = word[23:8];
			FMT_INT32: res.int_val = word[31:16];
			FMT_FLOAT: begin
				if (bexp == 8'hFF && frac != 23'd0) begin
					res.kind = KIND_ZERO;
				end else if (bexp >= EXP_ONE) begin
					res.kind = KIND_FULL;
				end else if (bexp < EXP_MIN_NZ) begin
					res.kind = KIND_ZERO;
				end else begin
					res.kind = KIND_MUL;
				end
			end
			default: res.int_val = word[15:0];
		endcase
	end
endmodule

>>> rtl/core/ps16_norm.sv
// Rounds the scaled product to 24 significant bits, nearest even.
`timescale 1ns / 1ps
module ps16_norm (
	input  ps16_pkg::prod_t in_p,
	output ps16_pkg::rnd_t  res
);
	import ps16_pkg::*;
	logic [23:0] r_raw;
	logic [14:0] lo;
	logic [14:0] hf;
	logic [7:0]  t_full;
	logic        up;

	always_comb begin
		if (in_p.prod[38]) begin
			r_raw  = in_p.prod[38:15];
			lo     = in_p.prod[14:0];
			hf     = 15'h4000;
			t_full = 8'd150 - in_p.bexp - 8'd15;
		end else begin
			r_raw  = in_p.prod[37:14];
			lo     = {1'b0, in_p.prod[13:0]};
			hf     = 15'h2000;
			t_full = 8'd150 - in_p.bexp - 8'd14;
		end
		up = (lo > hf) || (lo == hf && r_raw[0]);
		res.r = {1'b0, r_raw} + {24'd0, up};
		res.t = t_full[4:0];
		res.kind = in_p.kind;
		res.sign = in_p.sign;
		res.int_val = in_p.int_val;
		res.last = in_p.last;
	end
endmodule

>>> rtl/core/ps16_final.sv
// Integer rounding, clamp and sign application for the float path.
`timescale 1ns / 1ps
module ps16_final (
	input  ps16_pkg::rnd_t in_r,
	output logic [15:0]    sample
);
	import ps16_pkg::*;
	logic [24:0] ip;
	logic [24:0] mask;
	logic [24:0] half;
	logic [24:0] rem;
	logic [25:0] ipr;
	logic [14:0] mag;

	always_comb begin
		ip   = in_r.r >> in_r.t;
		mask = (25'd1 << in_r.t) - 25'd1;
		half = 25'd1 << (in_r.t - 5'd1);
		rem  = in_r.r & mask;
		ipr  = {1'b0, ip} + {25'd0, (rem > half) || (rem == half && ip[0])};
		mag  = (ipr > {11'd0, FULL_SCALE}) ? FULL_SCALE : ipr[14:0];
		unique case (in_r.kind)
			KIND_INT:  sample = in_r.int_val;
			KIND_ZERO: sample = 16'd0;
			KIND_FULL: sample = in_r.sign ? -{1'b0, FULL_SCALE} : {1'b0, FULL_SCALE};
			KIND_MUL:  sample = in_r.sign ? -{1'b0, mag} : {1'b0, mag};
			default:   sample = 16'd0;
		endcase
	end
endmodule

>>> rtl/core/pcm_sample_to_s16_converter.sv
// Top level of the PCM sample to signed 16-bit converter.
`timescale 1ns / 1ps
// The converter takes one raw sample word per transfer and returns one signed
// 16-bit sample per transfer, in order, with last copied through. Formats are
// chosen by source_format: int16 passthrough, packed int24, int32, or IEEE
// single float scaled by 32767 with the float's rounding rules, NaN giving
// zero. It accepts a new transfer every cycle unless the output is stalled
// while valid. A sample passes through the input register, the multiply
// register, the significand rounding register and the output register, in
// that order. The whole pipeline advances together and holds when the
// output is stalled while valid, so in_stall follows out_stall in that
// case only. Write source_format only while no samples are in flight.
module pcm_sample_to_s16_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               source_format_we,
	input  logic [1:0]         source_format_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        sample_word,
	input  logic               last_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output logic               last_out
);
	import ps16_pkg::*;

	logic [1:0]  fmt_q;
	logic        adv;
	logic        v_s1, v_s2, v_s3, out_valid_q;
	logic [31:0] word_s1;
	logic [1:0]  fmt_s1;
	logic        last_s1;
	prod_t       prod_c, prod_s2;
	rnd_t        rnd_c, rnd_s3;
	logic [15:0] sample_c;
	logic [15:0] sample_q;
	logic        last_q;

	// The pipeline only halts when a finished sample is being held back.
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_INT16;
		end else if (source_format_we) begin
			fmt_q <= source_format_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1  <= sample_word;
			fmt_s1   <= fmt_q;
			last_s1  <= last_in;
			prod_s2  <= prod_c;
			rnd_s3   <= rnd_c;
			sample_q <= sample_c;
			last_q   <= rnd_s3.last;
		end
	end

	ps16_decode u_decode (
		.word (word_s1),
		.fmt  (fmt_s1),
		.last (last_s1),
		.res  (prod_c)
	);

	ps16_norm u_norm (
		.in_p (prod_s2),
		.res  (rnd_c)
	);

	ps16_final u_final (
		.in_r   (rnd_s3),
		.sample (sample_c)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign last_out   = last_q;
endmodule

>>> bench/pcm_sample_to_s16_converter_test.sv
// Testbench for the PCM sample to signed 16-bit converter.
`timescale 1ns / 1ps
module pcm_sample_to_s16_converter_test;
	import ps16_pkg::*;

	typedef struct {
		logic signed [15:0] sample;
		logic               last;
	} s16_result_t;

	// Computes the converted sample for one word and keeps the converted samples
	// that are still owed by the block, oldest first.
	class s16_scoreboard;
		s16_result_t pending[$];
		logic [1:0]  format;
		int          mismatches;

		function new();
			format = FMT_INT16;
			mismatches = 0;
		endfunction

		// Float encoding to a scaled sample: clamp to [-1,1], multiply by full
		// scale rounded to 24 significant bits, then round to an integer. Both
		// roundings are to nearest, ties to even.
		static function automatic logic [15:0] scale_float(logic [31:0] w);
			logic        sgn;
			logic [7:0]  bexp;
			logic [22:0] frac;
			longint unsigned mant, q, r, lo, hf, ip, rem, half;
			int len, drop, s, t, mag;
			sgn = w[31];
			bexp = w[30:23];
			frac = w[22:0];
			if (bexp == 8'hFF && frac != 0)
				return 16'd0;
			if (bexp >= EXP_ONE) begin
				mag = FULL_SCALE;
			end else if (bexp == 0 && frac == 0) begin
				mag = 0;
			end else begin
				if (bexp == 0) begin
					mant = frac;
					s = 149;
				end else begin
					mant = {41'd1, frac};
					s = 150 - bexp;
				end
				q = mant * FULL_SCALE;
				len = 0;
				while (len < 64 && (q >> len) != 0)
					len++;
				drop = (len > 24) ? len - 24 : 0;
				r = q;
				if (drop > 0) begin
					lo = q & ((64'd1 << drop) - 1);
					hf = 64'd1 << (drop - 1);
					r = q >> drop;
					if (lo > hf || (lo == hf && r[0]))
						r++;
				end
				t = s - drop;
				if (t >= 63) begin
					mag = 0;
				end else if (t == 0) begin
					mag = r;
				end else begin
					ip = r >> t;
					rem = r & ((64'd1 << t) - 1);
					half = 64'd1 << (t - 1);
					if (rem > half || (rem == half && ip[0]))
						ip++;
					if (ip > FULL_SCALE)
						ip = FULL_SCALE;
					mag = ip;
				end
			end
			return sgn ? 16'(-mag) : 16'(mag);
		endfunction

		function void note_input(logic [31:0] w, logic last);
			s16_result_t e;
			case (format)
				FMT_INT24: e.sample = w[23:8];
				FMT_INT32: e.sample = w[31:16];
				FMT_FLOAT: e.sample = scale_float(w);
				default:   e.sample = w[15:0];
			endcase
			e.last = last;
			pending.push_back(e);
		endfunction

		function void check_result(logic signed [15:0] sample, logic last);
			s16_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output sample %0d last %0b", sample, last);
				return;
			end
			e = pending.pop_front();
			if (sample !== e.sample || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample mismatch: expected %0d last %0b, got %0d last %0b",
						e.sample, e.last, sample, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic source_format_we;
	logic [1:0] source_format_wdata;
	logic in_valid;
	logic in_stall;
	logic [31:0] sample_word;
	logic last_in;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] sample_out;
	logic last_out;

	s16_scoreboard sb = new();

	// Idle percentages per side; they change from phase to phase.
	int sender_idle_pct;
	int receiver_idle_pct;
	int quiet_cycles = 0;

	localparam int QUIET_LIMIT = 5000;
	localparam int PIPE_LATENCY = 4;

	pcm_sample_to_s16_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.source_format_we(source_format_we),
		.source_format_wdata(source_format_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_word(sample_word),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.last_out(last_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides its stall at each falling edge and checks each
	// output transfer at the rising edge, before the block updates its outputs.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(sample_out, last_out);
	end

	// Watchdog: any cycle with neither transfer counts toward the limit.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one sample, idling first at random. Valid stays high after the
	// transfer so that back-to-back samples never drop it within a step.
	task automatic send_sample(logic [31:0] w, logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample_word = w;
		last_in = last;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
			@(negedge clk);
		end
		sb.note_input(w, last);
		@(negedge clk);
	endtask

	// Drops valid and waits until every owed sample has come out and the
	// pipeline has had time to empty.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// The format register is only written with nothing in flight.
	task automatic set_format(logic [1:0] fmt);
		drain();
		source_format_we = 1'b1;
		source_format_wdata = fmt;
		@(negedge clk);
		source_format_we = 1'b0;
		sb.format = fmt;
	endtask

	// Random words: in float mode most exponents sit around the interesting
	// range near one, where both roundings matter; the rest are raw bits.
	function automatic logic [31:0] random_word(logic [1:0] fmt);
		logic [31:0] w;
		w = $urandom;
		if (fmt == FMT_FLOAT && $urandom_range(3) != 0)
			w[30:23] = 8'($urandom_range(EXP_ONE + 2, EXP_MIN_NZ - 4));
		return w;
	endfunction

	initial begin
		logic [1:0] fmts[4];
		logic [31:0] int_edges[4];
		logic [31:0] float_edges[13];
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		in_valid = 1'b0;
		sample_word = '0;
		last_in = 1'b0;
		source_format_we = 1'b0;
		source_format_wdata = FMT_INT16;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: integer extremes under the reset format and the other
		// integer formats, then float edge cases: signed zeros, exactly one,
		// infinities, NaN, denormals, ties and values that round away to zero.
		int_edges = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0080_8000, 32'h7FFF_7FFF};
		foreach (int_edges[i])
			send_sample(int_edges[i], i[0]);
		set_format(FMT_INT24);
		foreach (int_edges[i])
			send_sample(int_edges[i], ~i[0]);
		set_format(FMT_INT32);
		foreach (int_edges[i])
			send_sample(int_edges[i], i[0]);
		set_format(FMT_FLOAT);
		float_edges = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
			32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h3F00_0000, 32'h3780_0000, 32'h3800_0000,
			32'hBF7F_FFFF};
		foreach (float_edges[i])
			send_sample(float_edges[i], i[0]);

		// Random part: three idle patterns, each running through all formats.
		// Every format change drains first, so the sender also pauses until all
		// owed samples have come out.
		fmts = '{FMT_FLOAT, FMT_INT16, FMT_INT24, FMT_INT32};
		for (int mode = 0; mode < 3; mode++) begin
			sender_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 54 : 0;
			receiver_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 6 : 0;
			foreach (fmts[f]) begin
				set_format(fmts[f]);
				repeat (58)
					send_sample(random_word(fmts[f]), 1'($urandom_range(1)));
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
